@@ rtl/fmsc_pkg.sv @@
package fmsc_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_CAND   = 2'd2,
        OP_END    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        SK_MATCH = 2'd0,
        SK_MISS  = 2'd1,
        SK_TAIL  = 2'd2
    } t_score_kind;

    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] UPPER_FIRST = 8'h41;
    localparam logic [7:0] UPPER_LAST  = 8'h5A;
    localparam logic [7:0] CASE_BIT    = 8'h20;
    localparam int         STEP_WEIGHT = 10;
    localparam int         CH_BITS     = 8;

    function automatic logic [7:0] fold_ch(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[UPPER_FIRST:UPPER_LAST]}) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

@@ rtl/fmsc_pat_mem.sv @@
module fmsc_pat_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [fmsc_pkg::CH_BITS-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [fmsc_pkg::CH_BITS-1:0] o_rdata
);
    import fmsc_pkg::*;

    logic [CH_BITS-1:0] r_mem [DEPTH];
    logic [CH_BITS-1:0] r_rdata;

    // A write to the entry being read in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fmsc_score.sv @@
module fmsc_score #(
    parameter int SCORE_BITS = 16,
    parameter int CW         = 6
) (
    input  fmsc_pkg::t_score_kind   i_kind,
    input  logic                    i_case_diff,
    input  logic [CW-1:0]           i_run,
    input  logic signed [SCORE_BITS-1:0] i_score,
    output logic signed [SCORE_BITS-1:0] o_score
);
    import fmsc_pkg::*;

    localparam int SW = ((SCORE_BITS > CW + 4) ? SCORE_BITS : CW + 4) + 2;
    localparam longint SMAX_L = (64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1;
    localparam longint SMIN_L = -(64'sd1 <<< (SCORE_BITS - 1));
    localparam logic signed [SW-1:0] SMAX = SW'(SMAX_L);
    localparam logic signed [SW-1:0] SMIN = SW'(SMIN_L);
    localparam logic signed [SW-1:0] WEIGHT = SW'(STEP_WEIGHT);

    logic signed [SW-1:0] run_ext;
    logic signed [SW-1:0] delta;
    logic signed [SW-1:0] sum;

    always_comb begin
        run_ext = SW'($signed({1'b0, i_run}));
        case (i_kind)
            SK_MATCH: delta = (run_ext <<< 3) + (run_ext <<< 1)
                              - SW'($signed({1'b0, i_case_diff}));
            SK_MISS:  delta = -WEIGHT;
            SK_TAIL:  delta = -SW'(1);
            default:  delta = '0;
        endcase
        sum = SW'(i_score) + delta;
        if (sum > SMAX) begin
            o_score = SCORE_BITS'(SMAX);
        end else if (sum < SMIN) begin
            o_score = SCORE_BITS'(SMIN);
        end else begin
            o_score = SCORE_BITS'(sum);
        end
    end

endmodule

@@ rtl/fuzzy_match_scorer.sv @@
// Fuzzy subsequence scorer with a stored pattern.
// Input stream: tuser carries the opcode (clear pattern, append pattern
// character, candidate character, end of candidate) and tdata the character.
// Pattern characters sit in a single-port-write, registered-read memory; the
// entry at the current match position is prefetched every cycle, with a
// write to that same entry forwarded, so one beat is taken every cycle while tready is high.
// Output stream: one beat per end-of-candidate beat, carrying the matched
// flag and the saturated score (zero when not matched). It appears in the
// cycle after the end beat is accepted, from an output register.
// A stalled receiver holds that register; the input keeps flowing until
// the register is full and the receiver still does not take it, and only
// then is the input tready dropped.
// Reset empties the pattern and starts a fresh candidate; stored pattern
// bytes are not cleared, and no result is pending after reset.
module fuzzy_match_scorer #(
    parameter int PATTERN_MAX = 32,
    parameter int SCORE_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  logic [7:0] i_s_tdata,   // ch[7:0]
    input  logic [1:0] i_s_tuser,   // opcode[1:0]
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // matched[0], score[SCORE_BITS:1], zero fill above
    output logic [((SCORE_BITS + 8) / 8) * 8 - 1:0] o_m_tdata
);
    import fmsc_pkg::*;

    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int DW = ((SCORE_BITS + 8) / 8) * 8;
    localparam logic [CW-1:0] LEN_MAX = CW'(PATTERN_MAX);

    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_run, n_run;
    logic signed [SCORE_BITS-1:0] r_score, n_score;
    logic r_out_valid, n_out_valid;
    logic r_out_matched, n_out_matched;
    logic signed [SCORE_BITS-1:0] r_out_score, n_out_score;

    t_opcode op;
    logic accept;
    logic mem_we;
    logic [CH_BITS-1:0] pat_ch;
    t_score_kind kind;
    logic case_diff;
    logic signed [SCORE_BITS-1:0] upd_score;
    logic ch_is_space;
    logic is_match;
    logic matched_now;

    assign op          = t_opcode'(i_s_tuser);
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;
    assign ch_is_space = (i_s_tdata == SPACE_CHAR);
    assign is_match    = (fold_ch(i_s_tdata) == fold_ch(pat_ch));
    assign case_diff   = (i_s_tdata != pat_ch);
    assign matched_now = (r_pos >= r_len);

    fmsc_pat_mem #(
        .DEPTH (PATTERN_MAX),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_s_tdata),
        .i_raddr (n_pos[AW-1:0]),
        .o_rdata (pat_ch)
    );

    fmsc_score #(
        .SCORE_BITS (SCORE_BITS),
        .CW         (CW)
    ) u_score (
        .i_kind      (kind),
        .i_case_diff (case_diff),
        .i_run       (r_run),
        .i_score     (r_score),
        .o_score     (upd_score)
    );

    always_comb begin
        n_len         = r_len;
        n_pos         = r_pos;
        n_run         = r_run;
        n_score       = r_score;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_out_matched = r_out_matched;
        n_out_score   = r_out_score;
        mem_we        = 1'b0;
        kind          = SK_TAIL;
        if (!matched_now) begin
            kind = is_match ? SK_MATCH : SK_MISS;
        end
        if (accept) begin
            case (op)
                OP_CLEAR: begin
                    n_len   = '0;
                    n_pos   = '0;
                    n_run   = '0;
                    n_score = '0;
                end
                OP_APPEND: begin
                    if (!ch_is_space && (r_len < LEN_MAX)) begin
                        mem_we = 1'b1;
                        n_len  = r_len + CW'(1);
                    end
                end
                OP_CAND: begin
                    if (matched_now) begin
                        n_score = upd_score;
                    end else if (!ch_is_space) begin
                        n_score = upd_score;
                        if (is_match) begin
                            n_run = r_run + CW'(1);
                            n_pos = r_pos + CW'(1);
                        end else begin
                            n_run = '0;
                        end
                    end
                end
                OP_END: begin
                    n_out_valid   = 1'b1;
                    n_out_matched = matched_now;
                    n_out_score   = matched_now ? r_score : '0;
                    n_pos         = '0;
                    n_run         = '0;
                    n_score       = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pos       <= '0;
            r_run       <= '0;
            r_score     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_run       <= n_run;
            r_score     <= n_score;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_matched <= n_out_matched;
        r_out_score   <= n_out_score;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DW'({r_out_score, r_out_matched});

endmodule

@@ bench/fuzzy_match_scorer_check.sv @@
module fuzzy_match_scorer_check #(
    parameter int PATTERN_MAX = 32,
    parameter int SCORE_BITS  = 16,
    parameter int OUT_W       = ((SCORE_BITS + 8) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [7:0]       i_s_tdata,   // ch[7:0]
    input  logic [1:0]       i_s_tuser,   // opcode[1:0]
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,   // matched[0], score[SCORE_BITS:1], zero fill above
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fmsc_pkg::*;

    typedef struct {
        logic                         matched;
        logic signed [SCORE_BITS-1:0] score;
    } t_verdict;

    logic [7:0] pattern_bytes [PATTERN_MAX];
    int         pattern_len;
    int         match_pos;
    int         run_len;
    longint     score_acc;
    t_verdict   expected_verdicts [$];

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic longint clamp_score(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SCORE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    task automatic restart_candidate();
        match_pos = 0;
        run_len   = 0;
        score_acc = 0;
    endtask

    task automatic predict_beat(input t_opcode op, input logic [7:0] c);
        t_verdict   v;
        logic [7:0] p;
        case (op)
            OP_CLEAR: begin
                pattern_len = 0;
                restart_candidate();
            end
            OP_APPEND: begin
                if (c != SPACE_CHAR && pattern_len < PATTERN_MAX) begin
                    pattern_bytes[pattern_len] = c;
                    pattern_len++;
                end
            end
            OP_CAND: begin
                if (match_pos < pattern_len) begin
                    if (c != SPACE_CHAR) begin
                        p = pattern_bytes[match_pos];
                        if (lower_byte(c) == lower_byte(p)) begin
                            score_acc = clamp_score(score_acc + run_len * STEP_WEIGHT
                                                    - ((c != p) ? 1 : 0));
                            run_len++;
                            match_pos++;
                        end else begin
                            score_acc = clamp_score(score_acc - STEP_WEIGHT);
                            run_len   = 0;
                        end
                    end
                end else begin
                    score_acc = clamp_score(score_acc - 1);
                end
            end
            default: begin
                v.matched = (match_pos >= pattern_len);
                v.score   = v.matched ? score_acc[SCORE_BITS-1:0] : '0;
                expected_verdicts.push_back(v);
                restart_candidate();
            end
        endcase
    endtask

    task automatic compare_result(input logic [OUT_W-1:0] d);
        t_verdict                     v;
        logic signed [SCORE_BITS-1:0] got_score;
        got_score = d[SCORE_BITS:1];
        if (expected_verdicts.size() == 0) begin
            $error("result beat with nothing expected: matched=%0d score=%0d",
                   d[0], got_score);
            o_fail_count++;
        end else begin
            v = expected_verdicts.pop_front();
            if (d[0] !== v.matched) begin
                $error("matched mismatch: expected %0d, got %0d", v.matched, d[0]);
                o_fail_count++;
            end
            if (got_score !== v.score) begin
                $error("score mismatch: expected %0d, got %0d", v.score, got_score);
                o_fail_count++;
            end
            if ((d >> (SCORE_BITS + 1)) !== '0) begin
                $error("zero fill mismatch: expected 0, got %0h", d >> (SCORE_BITS + 1));
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pattern_len  = 0;
            restart_candidate();
            expected_verdicts.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                compare_result(i_m_tdata);
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_beat(t_opcode'(i_s_tuser), i_s_tdata);
            end
        end
        o_pending = expected_verdicts.size();
    end

endmodule

@@ bench/fuzzy_match_scorer_tb.sv @@
module fuzzy_match_scorer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fmsc_pkg::*;

    localparam int PATTERN_MAX = 32;
    localparam int SCORE_BITS  = 16;
    localparam int OUT_W       = ((SCORE_BITS + 8) / 8) * 8;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending_results;

    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_left;
    int               beats_sent;
    logic [7:0]       pattern_chars [$];

    fuzzy_match_scorer #(
        .PATTERN_MAX(PATTERN_MAX),
        .SCORE_BITS (SCORE_BITS)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    fuzzy_match_scorer_check #(
        .PATTERN_MAX(PATTERN_MAX),
        .SCORE_BITS (SCORE_BITS),
        .OUT_W      (OUT_W)
    ) u_score_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending_results)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // The receiver runs a long hold-off first whenever one is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [7:0] random_char();
        logic [7:0] edge_bytes [8];
        logic [7:0] c;
        edge_bytes = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
        case ($urandom_range(9))
            0: c = 8'($urandom_range(255));
            1: c = SPACE_CHAR;
            2: c = edge_bytes[$urandom_range(7)];
            default: begin
                c = 8'h61 + 8'($urandom_range(4));
                if ($urandom_range(1)) begin
                    c = c ^ CASE_BIT;
                end
            end
        endcase
        return c;
    endfunction

    task automatic send_beat(input t_opcode op, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = c;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        beats_sent++;
    endtask

    function automatic logic lower_byte_is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    task automatic send_candidate();
        int         kind;
        int         stop_at;
        logic [7:0] c;
        kind    = $urandom_range(9);
        stop_at = (kind == 6) ? $urandom_range(pattern_chars.size()) : pattern_chars.size();
        if (kind < 8) begin
            for (int i = 0; i < stop_at; i++) begin
                repeat ($urandom_range(2)) send_beat(OP_CAND, random_char());
                c = pattern_chars[i];
                if (lower_byte_is_letter(c) && $urandom_range(1)) begin
                    c = c ^ CASE_BIT;
                end
                send_beat(OP_CAND, c);
                if ($urandom_range(39) == 0) begin
                    c = random_char();
                    send_beat(OP_APPEND, c);
                    if (c != SPACE_CHAR) begin
                        pattern_chars.push_back(c);
                    end
                end
            end
            repeat ($urandom_range(3)) send_beat(OP_CAND, random_char());
        end else begin
            repeat ($urandom_range(8)) send_beat(OP_CAND, random_char());
        end
        send_beat(OP_END, 8'($urandom_range(255)));
    endtask

    task automatic run_random(input int count);
        int         stop_count;
        int         len;
        logic [7:0] c;
        stop_count = beats_sent + count;
        while (beats_sent < stop_count) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 36) : $urandom_range(6);
            send_beat(OP_CLEAR, 8'($urandom_range(255)));
            pattern_chars.delete();
            repeat (len) begin
                c = random_char();
                send_beat(OP_APPEND, c);
                if (c != SPACE_CHAR) begin
                    pattern_chars.push_back(c);
                end
            end
            repeat ($urandom_range(1, 4)) send_candidate();
            if ($urandom_range(3) == 0) begin
                send_beat(t_opcode'(2'($urandom_range(3))), 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_results != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_CLEAR;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        beats_sent     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_beat(OP_END, 8'h00);
        send_beat(OP_CAND, 8'h61);
        send_beat(OP_CAND, SPACE_CHAR);
        send_beat(OP_END, 8'hFF);
        send_beat(OP_APPEND, 8'h41);
        send_beat(OP_APPEND, SPACE_CHAR);
        send_beat(OP_APPEND, 8'h62);
        send_beat(OP_APPEND, 8'hFF);
        send_beat(OP_APPEND, 8'h00);
        send_beat(OP_CAND, 8'h61);
        send_beat(OP_CAND, SPACE_CHAR);
        send_beat(OP_CAND, 8'h42);
        send_beat(OP_CAND, 8'h78);
        send_beat(OP_CAND, 8'hFF);
        send_beat(OP_CAND, 8'h00);
        send_beat(OP_CAND, 8'h7A);
        send_beat(OP_CAND, SPACE_CHAR);
        send_beat(OP_END, 8'h55);
        send_beat(OP_CAND, 8'h61);
        send_beat(OP_CLEAR, 8'hFF);
        send_beat(OP_APPEND, 8'h6B);
        send_beat(OP_CAND, 8'h4B);
        send_beat(OP_APPEND, 8'h6D);
        send_beat(OP_CAND, 8'h6D);
        send_beat(OP_END, 8'hAA);
        send_beat(OP_APPEND, 8'h71);
        send_beat(OP_END, 8'h00);

        // A long miss streak drives the score deep into negative values.
        send_beat(OP_CLEAR, 8'h00);
        send_beat(OP_APPEND, 8'h61);
        repeat (60) send_beat(OP_CAND, 8'h62);
        send_beat(OP_CAND, 8'h41);
        send_beat(OP_END, 8'h00);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_left      = 300;
                end
                1: begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 59;
                end
                default: begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase
            run_random(240);
            s_tvalid = 1'b0;
            drain_results();
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/fmsc_pkg.sv
rtl/fmsc_pat_mem.sv
rtl/fmsc_score.sv
rtl/fuzzy_match_scorer.sv
bench/fuzzy_match_scorer_check.sv
bench/fuzzy_match_scorer_tb.sv
